// ----- hdl/wavp_pkg.sv -----
`default_nettype none

package wavp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FORMAT_PCM  = 16'd1;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CHUNK  = 3'd1,
		PH_FMT    = 3'd2,
		PH_SKIP   = 3'd3,
		PH_IDLE   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TAG   = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_NO_FMT    = 3'd3,
		ST_NOT_PCM   = 3'd4,
		ST_FMT_SHORT = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       first;
		logic       last;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] srate;
		logic [15:0] channels;
		logic [15:0] sample_width;
		logic [31:0] payload_offset;
		logic [31:0] payload_size;
	} out_item_t;

endpackage

`default_nettype wire

// ----- hdl/wavp_stream_if.sv -----
`default_nettype none

interface wavp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/wav_header_parser.sv -----
// Latency: a result is valid in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; the parse state advances in a single register stage.
// While a result waits, the next byte is accepted only in the cycle the result is taken.
// Reset (arst_n low, asynchronous) clears the phase, the counters, the captured
// format fields and the result valid flag.
`default_nettype none

module wav_header_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	wavp_stream_if.sink      bytes,
	wavp_stream_if.source    result
);

	wavp_pkg::phase_t    phase_q, phase_n;
	logic [3:0]          field_q, field_n;
	logic [31:0]         tag_q, tag_n;
	logic [31:0]         len_q, len_n;
	logic [32:0]         skip_q, skip_n;
	logic [31:0]         offset_q, offset_n;
	logic [15:0]         format_q, format_n;
	logic [31:0]         rate_q, rate_n;
	logic [15:0]         chan_q, chan_n;
	logic [15:0]         bits_q, bits_n;
	logic                fmt_seen_q, fmt_seen_n;

	logic                emit;
	wavp_pkg::status_t   status_n;
	wavp_pkg::out_item_t res_d;
	wavp_pkg::out_item_t res_q;
	logic                res_valid_q;
	logic                acc;
	logic [7:0]          b;

	assign b     = bytes.data.byte_in;
	assign acc   = bytes.valid && bytes.ready;
	assign bytes.ready = !res_valid_q || result.ready;

	// Next-state logic for one accepted byte.
	always_comb begin
		phase_n    = phase_q;
		field_n    = field_q;
		tag_n      = tag_q;
		len_n      = len_q;
		skip_n     = skip_q;
		offset_n   = offset_q;
		format_n   = format_q;
		rate_n     = rate_q;
		chan_n     = chan_q;
		bits_n     = bits_q;
		fmt_seen_n = fmt_seen_q;
		emit       = 1'b0;
		status_n   = wavp_pkg::ST_OK;

		if (bytes.data.first) begin
			phase_n    = wavp_pkg::PH_HEADER;
			field_n    = '0;
			tag_n      = '0;
			len_n      = '0;
			skip_n     = '0;
			offset_n   = '0;
			format_n   = '0;
			rate_n     = '0;
			chan_n     = '0;
			bits_n     = '0;
			fmt_seen_n = 1'b0;
		end

		if (phase_n != wavp_pkg::PH_IDLE) begin
			offset_n = offset_n + 32'd1;
			unique case (phase_n)
				wavp_pkg::PH_HEADER: begin
					tag_n = {b, tag_n[31:8]};
					if (field_n == 4'd3 && tag_n != wavp_pkg::TAG_RIFF) begin
						emit     = 1'b1;
						status_n = wavp_pkg::ST_BAD_TAG;
					end else if (field_n == 4'd11) begin
						if (tag_n != wavp_pkg::TAG_WAVE) begin
							emit     = 1'b1;
							status_n = wavp_pkg::ST_BAD_TAG;
						end else begin
							field_n = '0;
							phase_n = wavp_pkg::PH_CHUNK;
						end
					end else begin
						field_n = field_n + 4'd1;
					end
				end
				wavp_pkg::PH_CHUNK: begin
					if (field_n < 4'd4) begin
						tag_n = {b, tag_n[31:8]};
					end else begin
						len_n = {b, len_n[31:8]};
					end
					if (field_n == 4'd7) begin
						field_n = '0;
						if (tag_n == wavp_pkg::TAG_DATA) begin
							emit = 1'b1;
							if (!fmt_seen_n) begin
								status_n = wavp_pkg::ST_NO_FMT;
							end else if (format_n != wavp_pkg::FORMAT_PCM) begin
								status_n = wavp_pkg::ST_NOT_PCM;
							end else begin
								status_n = wavp_pkg::ST_OK;
							end
						end else if (tag_n == wavp_pkg::TAG_FMT) begin
							if (len_n < wavp_pkg::FMT_MIN_LEN) begin
								emit     = 1'b1;
								status_n = wavp_pkg::ST_FMT_SHORT;
							end else begin
								skip_n  = {1'b0, len_n - wavp_pkg::FMT_MIN_LEN}
									+ {32'd0, len_n[0]};
								phase_n = wavp_pkg::PH_FMT;
							end
						end else begin
							// Odd-sized chunks carry one pad byte.
							skip_n  = {1'b0, len_n} + {32'd0, len_n[0]};
							phase_n = (skip_n == '0) ? wavp_pkg::PH_CHUNK
								: wavp_pkg::PH_SKIP;
						end
					end else begin
						field_n = field_n + 4'd1;
					end
				end
				wavp_pkg::PH_FMT: begin
					if (field_n < 4'd2) begin
						format_n[{field_n[0], 3'b000} +: 8] = b;
					end else if (field_n < 4'd4) begin
						chan_n[{field_n[0], 3'b000} +: 8] = b;
					end else if (field_n < 4'd8) begin
						rate_n[{field_n[1:0], 3'b000} +: 8] = b;
					end else if (field_n >= 4'd14) begin
						bits_n[{field_n[0], 3'b000} +: 8] = b;
					end
					if (field_n == 4'd15) begin
						fmt_seen_n = 1'b1;
						field_n    = '0;
						phase_n    = (skip_n == '0) ? wavp_pkg::PH_CHUNK
							: wavp_pkg::PH_SKIP;
					end else begin
						field_n = field_n + 4'd1;
					end
				end
				wavp_pkg::PH_SKIP: begin
					if (skip_n != '0) begin
						skip_n = skip_n - 33'd1;
					end
					if (skip_n == '0) begin
						field_n = '0;
						phase_n = wavp_pkg::PH_CHUNK;
					end
				end
				default: ;
			endcase

			if (!emit && bytes.data.last) begin
				emit     = 1'b1;
				status_n = wavp_pkg::ST_TRUNC;
			end
			if (emit) begin
				phase_n = wavp_pkg::PH_IDLE;
			end
		end
	end

	// Result payload; offset and size are reported only for a good header.
	always_comb begin
		res_d.status         = status_n;
		res_d.srate          = rate_n;
		res_d.channels       = chan_n;
		res_d.sample_width   = bits_n;
		res_d.payload_offset = '0;
		res_d.payload_size   = '0;
		if (status_n == wavp_pkg::ST_OK) begin
			res_d.payload_offset = offset_n;
			res_d.payload_size   = len_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wavp_pkg::PH_HEADER;
			field_q    <= '0;
			tag_q      <= '0;
			len_q      <= '0;
			skip_q     <= '0;
			offset_q   <= '0;
			format_q   <= '0;
			rate_q     <= '0;
			chan_q     <= '0;
			bits_q     <= '0;
			fmt_seen_q <= 1'b0;
		end else if (acc) begin
			phase_q    <= phase_n;
			field_q    <= field_n;
			tag_q      <= tag_n;
			len_q      <= len_n;
			skip_q     <= skip_n;
			offset_q   <= offset_n;
			format_q   <= format_n;
			rate_q     <= rate_n;
			chan_q     <= chan_n;
			bits_q     <= bits_n;
			fmt_seen_q <= fmt_seen_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// An error result never carries a data offset or size.
	a_err_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != wavp_pkg::ST_OK)
		|-> (res_q.payload_offset == '0 && res_q.payload_size == '0))
		else $error("error result carries data offset or size");

	// Once a result is out, the parser is parked until a new file starts.
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> (phase_q == wavp_pkg::PH_IDLE))
		else $error("parser not idle after a result");

	// An idle parser ignores bytes that do not start a new file.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == wavp_pkg::PH_IDLE && !bytes.data.first) |-> !emit)
		else $error("result produced while idle");

	// A good result implies a complete PCM fmt chunk was captured.
	a_ok_has_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == wavp_pkg::ST_OK)
		|-> (fmt_seen_q && format_q == wavp_pkg::FORMAT_PCM))
		else $error("good result without a PCM fmt chunk");

endmodule

`default_nettype wire
